>>> hw/rtl/cvsp_pkg.sv
// shared types, constants and helpers for the constant velocity spring pull unit
`default_nettype none
package cvsp_pkg;
  localparam int MaxBeads = 1024;
  localparam int FracBits = 16;
  localparam int DirFrac = 14;
  localparam int CntW = $clog2(MaxBeads + 1);
  localparam int SumW = 48;

  localparam logic [2:0] REG_STIFF = 3'd0;
  localparam logic [2:0] REG_REST  = 3'd1;
  localparam logic [2:0] REG_SPEED = 3'd2;
  localparam logic [2:0] REG_DIRX  = 3'd3;
  localparam logic [2:0] REG_DIRY  = 3'd4;
  localparam logic [2:0] REG_DIRZ  = 3'd5;
  localparam logic [2:0] REG_START = 3'd6;

  typedef struct packed {
    logic [31:0] stiff;
    logic [31:0] rest;
    logic signed [31:0] speed;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [31:0] start;
  } cfg_t;

  // clip a wide signed value to signed 32 bit
  function automatic logic [32:0] clip32(input logic signed [95:0] v);
    logic [32:0] r;
    if (v > 96'sd2147483647) r = {1'b1, 32'h7fffffff};
    else if (v < -96'sd2147483648) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/cvsp_regs.sv
// apb register file for the spring pull configuration
`default_nettype none
module cvsp_regs import cvsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output cfg_t             cfg
);
  cfg_t cfg_r;
  logic [2:0] idx;
  assign idx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{stiff: 32'd65536, rest: '0, speed: '0, dir_x: 16'sd16384,
                 dir_y: '0, dir_z: '0, start: '0};
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (idx)
        REG_STIFF: cfg_r.stiff <= cfg_pwdata;
        REG_REST:  cfg_r.rest  <= cfg_pwdata;
        REG_SPEED: cfg_r.speed <= cfg_pwdata;
        REG_DIRX:  cfg_r.dir_x <= cfg_pwdata[15:0];
        REG_DIRY:  cfg_r.dir_y <= cfg_pwdata[15:0];
        REG_DIRZ:  cfg_r.dir_z <= cfg_pwdata[15:0];
        REG_START: cfg_r.start <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STIFF: cfg_prdata = cfg_r.stiff;
      REG_REST:  cfg_prdata = cfg_r.rest;
      REG_SPEED: cfg_prdata = cfg_r.speed;
      REG_DIRX:  cfg_prdata = {{16{cfg_r.dir_x[15]}}, cfg_r.dir_x};
      REG_DIRY:  cfg_prdata = {{16{cfg_r.dir_y[15]}}, cfg_r.dir_y};
      REG_DIRZ:  cfg_prdata = {{16{cfg_r.dir_z[15]}}, cfg_r.dir_z};
      REG_START: cfg_prdata = cfg_r.start;
      default:   cfg_prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

>>> hw/rtl/cvsp_divu.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module cvsp_divu import cvsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [95:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [95:0]      quotient
);
  logic [95:0] q_r;
  logic [63:0] rem_r;
  logic [63:0] d_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] trial;
  assign trial = {rem_r, q_r[95]} - {1'b0, d_r};
  assign quotient = q_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 7'd96;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      rem_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_r <= trial[63:0];
        q_r <= {q_r[94:0], 1'b1};
      end else begin
        rem_r <= {rem_r[62:0], q_r[95]};
        q_r <= {q_r[94:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/constant_velocity_spring_pull_force_unit.sv
// top level: bead accumulation and sequenced spring force evaluation
// sequence: a last bead starts the centroid divisions, then an anchor capture pass or a force pass
// throughput: one bead per cycle while accumulating, one pass at a time, a waiting result
//   stalls only the output step of the next pass
// reset: synchronous active low, clears sums, count, anchor, sequencer and output valid; registers take defaults
`default_nettype none
module constant_velocity_spring_pull_force_unit import cvsp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // pos_x, pos_y, pos_z, now_step
  input  wire logic         in_tuser,   // op
  input  wire logic         in_tlast,   // last_bead
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [135:0]      out_tdata,  // force_x, force_y, force_z, spring_extent,
                                        // zero_length, saturated, zero fill
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001, S_DIV  = 13'b0000000000010,
    S_DWT  = 13'b0000000000100, S_CAP  = 13'b0000000001000,
    S_TRV  = 13'b0000000010000, S_VEC  = 13'b0000000100000,
    S_SQ   = 13'b0000001000000, S_SQRT = 13'b0000010000000,
    S_KD   = 13'b0000100000000, S_FDIV = 13'b0001000000000,
    S_FWT  = 13'b0010000000000, S_OUT  = 13'b0100000000000,
    S_FMUL = 13'b1000000000000
  } state_t;

  cfg_t cfg;
  cvsp_regs u_regs (.clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg);

  state_t state_r;
  logic signed [SumW-1:0] sum_r [3];
  logic [CntW-1:0] cnt_r;
  logic signed [31:0] anc_r [3];
  logic signed [31:0] cen_r [3];
  logic signed [31:0] v_r [3];
  logic signed [31:0] f_r [3];
  logic [1:0] idx_r;
  logic op_r, sat_r, zero_r;
  logic [31:0] now_r;
  logic signed [95:0] trv_r;
  logic [65:0] sq_r;
  logic [65:0] rn_r, rres_r, rbit_r;
  logic [31:0] len_r;
  logic [63:0] kd_r;
  logic [63:0] pl_r;
  logic dneg_r;
  logic [135:0] out_r;
  logic out_v_r;

  logic div_start, div_done;
  logic [95:0] div_dnd, div_q;
  logic [63:0] div_dsr;
  cvsp_divu u_div (.clk, .rst_n, .start(div_start), .dividend(div_dnd),
    .divisor(div_dsr), .done(div_done), .quotient(div_q));

  logic signed [SumW-1:0] cur_sum;
  logic sneg;
  logic [SumW-1:0] smag;
  logic signed [15:0] cur_dir;
  logic signed [95:0] prod, vsum;
  logic [32:0] clip;
  logic [31:0] vmag;
  logic [65:0] rtry;
  logic [95:0] fq;
  logic fneg, fbig;

  assign in_tready = state_r == S_IDLE;
  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;

  always_comb begin
    cur_sum = sum_r[idx_r];
    sneg = cur_sum < 0;
    smag = sneg ? SumW'(-cur_sum) : cur_sum;
    case (idx_r)
      2'd0: cur_dir = cfg.dir_x;
      2'd1: cur_dir = cfg.dir_y;
      default: cur_dir = cfg.dir_z;
    endcase
    prod = (state_r == S_CAP) ? 96'($signed({1'b0, cfg.rest})) * 96'(cur_dir)
                              : trv_r * 96'(cur_dir);
    vsum = (state_r == S_CAP) ? 96'(cen_r[idx_r]) + (prod >>> DirFrac)
         : 96'(anc_r[idx_r]) + (prod >>> DirFrac) - 96'(cen_r[idx_r]);
    clip = clip32(vsum);
    vmag = v_r[idx_r][31] ? 32'(-v_r[idx_r]) : v_r[idx_r];
    rtry = rres_r + rbit_r;
    div_start = 1'b0;
    div_dnd = '0;
    div_dsr = '0;
    if (state_r == S_DIV) begin
      div_start = 1'b1;
      div_dnd = 96'(smag);
      div_dsr = 64'(cnt_r);
    end else if (state_r == S_FDIV) begin
      div_start = 1'b1;
      div_dnd = ((96'(kd_r[63:32]) * 96'(vmag)) << 32) + 96'(pl_r);
      div_dsr = {32'd0, len_r} << FracBits;
    end
    fq = div_q;
    fneg = dneg_r != v_r[idx_r][31];
    fbig = fq[95:64] != 0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_v_r <= 1'b0;
      idx_r <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
        anc_r[i] <= '0;
      end
    end else begin
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          if (cnt_r < CntW'(MaxBeads)) begin
            sum_r[0] <= sum_r[0] + SumW'($signed(in_tdata[31:0]));
            sum_r[1] <= sum_r[1] + SumW'($signed(in_tdata[63:32]));
            sum_r[2] <= sum_r[2] + SumW'($signed(in_tdata[95:64]));
            cnt_r <= cnt_r + 1'b1;
          end
          if (in_tlast) begin
            state_r <= S_DIV;
            idx_r <= '0;
            op_r <= in_tuser;
            now_r <= in_tdata[127:96];
            sat_r <= 1'b0;
          end
        end
        S_DIV: state_r <= S_DWT;
        S_DWT: if (div_done) begin
          cen_r[idx_r] <= sneg ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
          if (idx_r == 2'd2) begin
            idx_r <= '0;
            cnt_r <= '0;
            for (int i = 0; i < 3; i++) sum_r[i] <= '0;
            state_r <= op_r ? S_TRV : S_CAP;
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_DIV;
          end
        end
        S_CAP: begin
          anc_r[idx_r] <= $signed(clip[31:0]);
          if (idx_r == 2'd2) state_r <= S_IDLE;
          else idx_r <= idx_r + 1'b1;
        end
        S_TRV: begin
          trv_r <= 96'(cfg.speed) * 96'($signed({1'b0, now_r}) - $signed({1'b0, cfg.start}));
          state_r <= S_VEC;
          idx_r <= '0;
        end
        S_VEC: begin
          if (idx_r == 2'd0) begin
            if (trv_r > 96'sd1099511627776) begin
              trv_r <= 96'sd1099511627776;
              sat_r <= 1'b1;
            end else if (trv_r < -96'sd1099511627776) begin
              trv_r <= -96'sd1099511627776;
              sat_r <= 1'b1;
            end else begin
              v_r[0] <= $signed(clip[31:0]);
              if (clip[32]) sat_r <= 1'b1;
              idx_r <= 2'd1;
            end
          end else begin
            v_r[idx_r] <= $signed(clip[31:0]);
            if (clip[32]) sat_r <= 1'b1;
            if (idx_r == 2'd2) begin
              idx_r <= '0;
              sq_r <= '0;
              state_r <= S_SQ;
            end else idx_r <= idx_r + 1'b1;
          end
        end
        S_SQ: begin
          sq_r <= sq_r + 66'(vmag * vmag);
          if (idx_r == 2'd2) begin
            state_r <= S_SQRT;
            rres_r <= '0;
            rbit_r <= 66'd1 << 64;
            rn_r <= sq_r + 66'(vmag * vmag);
          end else idx_r <= idx_r + 1'b1;
        end
        S_SQRT: begin
          if (rbit_r == 0) begin
            len_r <= rres_r[31:0];
            dneg_r <= rres_r[31:0] < cfg.rest;
            state_r <= S_KD;
          end else begin
            if (rn_r >= rtry) begin
              rn_r <= rn_r - rtry;
              rres_r <= (rres_r >> 1) + rbit_r;
            end else rres_r <= rres_r >> 1;
            rbit_r <= rbit_r >> 2;
          end
        end
        S_KD: begin
          kd_r <= 64'(cfg.stiff) * 64'(dneg_r ? cfg.rest - len_r : len_r - cfg.rest);
          idx_r <= '0;
          zero_r <= len_r == 0;
          state_r <= (len_r == 0) ? S_OUT : S_FMUL;
        end
        S_FMUL: begin
          pl_r <= 64'(kd_r[31:0]) * 64'(vmag);
          state_r <= S_FDIV;
        end
        S_FDIV: state_r <= S_FWT;
        S_FWT: if (div_done) begin
          if (fneg) begin
            if (fbig || fq[63:0] > 64'h80000000) begin
              f_r[idx_r] <= 32'sh80000000;
              sat_r <= 1'b1;
            end else f_r[idx_r] <= $signed(-fq[31:0]);
          end else begin
            if (fbig || fq[63:0] > 64'h7fffffff) begin
              f_r[idx_r] <= 32'sh7fffffff;
              sat_r <= 1'b1;
            end else f_r[idx_r] <= $signed(fq[31:0]);
          end
          if (idx_r == 2'd2) state_r <= S_OUT;
          else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_FMUL;
          end
        end
        S_OUT: if (!out_v_r) begin
          out_r <= zero_r ? {6'd0, sat_r, 1'b1, 128'd0}
                          : {6'd0, sat_r, 1'b0, len_r, f_r[2], f_r[1], f_r[0]};
          out_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  ap_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready outside idle");
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> out_v_r) else $error("result dropped");
  ap_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxBeads)) else $error("bead count overflow");
endmodule
`default_nettype wire

>>> bench/tb_constant_velocity_spring_pull_force_unit.sv
// self-checking bench for the spring pull force unit: bead streams, force passes and register sweeps
module tb_constant_velocity_spring_pull_force_unit;
  import cvsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 3000000;
  localparam int PassDrain = 700;
  localparam int RandomBeads = 2000;

  typedef struct packed {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
    logic [31:0] extent;
    logic        zero_len;
    logic        sat;
  } force_t;

  typedef struct {
    logic        op;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        lb;
    logic [31:0] now;
    logic        typed;
    force_t      want;
  } row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser, in_tlast;
  logic [127:0] in_tdata;   // pos_x, pos_y, pos_z, now_step
  logic out_tvalid, out_tready;
  logic [135:0] out_tdata;  // force_x, force_y, force_z, spring_extent, zero_length, saturated
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  constant_velocity_spring_pull_force_unit dut (.*);

  // predictor state
  logic [31:0] k_reg, rest_reg, start_reg;
  logic signed [31:0] speed_reg;
  logic signed [15:0] dir_reg [3];
  longint bead_sum [3];
  int bead_cnt;
  longint anchor [3];

  force_t expected_forces [$];
  int mismatches, cycles, forces_seen, passes_done, captures_done;
  bit no_idle;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_forces.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic longint clip_s32(longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] hooke_comp(logic [63:0] kd, bit dneg, longint v,
                                             logic [31:0] len, inout bit sat);
    logic [127:0] q;
    logic [63:0] m;
    bit neg;
    neg = dneg != (v < 0);
    m = (v < 0) ? -v : v;
    q = ({64'd0, kd} * {64'd0, m}) / {96'd0, len};
    q = q >> FracBits;
    if (neg) begin
      if (q > 128'h8000_0000) begin
        sat = 1;
        return 32'h8000_0000;
      end
      return -q[31:0];
    end
    if (q > 128'h7fff_ffff) begin
      sat = 1;
      return 32'h7fff_ffff;
    end
    return q[31:0];
  endfunction

  // returns 1 when the bead closes a force pass
  function automatic bit spring_bead(logic op, logic [31:0] p [3], logic lb, logic [31:0] now,
                                     output force_t r);
    longint c [3], v [3], travel, diff;
    longint unsigned sq;
    logic [31:0] len, dl;
    logic [63:0] kd;
    bit sat, ign, dneg;
    sat = 0;
    ign = 0;
    r = '{default: 0};
    if (bead_cnt < MaxBeads) begin
      for (int i = 0; i < 3; i++) bead_sum[i] += longint'(signed'(p[i]));
      bead_cnt++;
    end
    if (!lb) return 0;
    for (int i = 0; i < 3; i++) begin
      c[i] = bead_sum[i] / bead_cnt;
      bead_sum[i] = 0;
    end
    bead_cnt = 0;
    passes_done++;
    if (!op) begin
      captures_done++;
      for (int i = 0; i < 3; i++)
        anchor[i] = clip_s32(c[i] + ((longint'({32'd0, rest_reg}) * dir_reg[i]) >>> DirFrac), ign);
      return 0;
    end
    diff = longint'({32'd0, now}) - longint'({32'd0, start_reg});
    travel = longint'(speed_reg) * diff;
    if (travel > (64'sd1 << 40)) begin
      travel = 64'sd1 << 40;
      sat = 1;
    end
    if (travel < -(64'sd1 << 40)) begin
      travel = -(64'sd1 << 40);
      sat = 1;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = clip_s32(anchor[i] + ((travel * dir_reg[i]) >>> DirFrac) - c[i], sat);
      sq += longint'(v[i] * v[i]);
    end
    len = floor_root(sq);
    if (len == 0) begin
      r.zero_len = 1;
    end else begin
      dneg = len < rest_reg;
      dl = dneg ? rest_reg - len : len - rest_reg;
      kd = {32'd0, k_reg} * {32'd0, dl};
      r.fx = hooke_comp(kd, dneg, v[0], len, sat);
      r.fy = hooke_comp(kd, dneg, v[1], len, sat);
      r.fz = hooke_comp(kd, dneg, v[2], len, sat);
      r.extent = len;
    end
    r.sat = sat;
    return 1;
  endfunction

  task automatic send_bead(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic lb, logic [31:0] now, bit typed, force_t want);
    int gap;
    logic [31:0] p [3];
    force_t r;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tlast <= lb;
    in_tdata <= {now, z, y, x};
    do @(posedge clk); while (!in_tready);
    p = '{x, y, z};
    if (spring_bead(op, p, lb, now, r)) expected_forces.push_back(typed ? want : r);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    case (idx)
      REG_STIFF: k_reg = val;
      REG_REST:  rest_reg = val;
      REG_SPEED: speed_reg = val;
      REG_DIRX:  dir_reg[0] = val[15:0];
      REG_DIRY:  dir_reg[1] = val[15:0];
      REG_DIRZ:  dir_reg[2] = val[15:0];
      default:   start_reg = val;
    endcase
  endtask

  // wait for every result, then for a capture pass that may still be running
  task automatic drain;
    in_tvalid <= 0;
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (PassDrain) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(0, 3))
      0: return 32'd16384;
      1: return -32'sd16384;
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  task automatic set_regs(int ph);
    drain();
    case (ph)
      1: begin
        write_reg(REG_STIFF, 32'hffff_ffff);
        write_reg(REG_REST, 32'hffff_ffff);
        write_reg(REG_SPEED, 32'h7fff_ffff);
        write_reg(REG_DIRX, 32'd16384);
        write_reg(REG_DIRY, -32'sd16384);
        write_reg(REG_DIRZ, 32'd16384);
        write_reg(REG_START, 32'd0);
      end
      2: begin
        write_reg(REG_STIFF, 32'd0);
        write_reg(REG_REST, 32'd0);
        write_reg(REG_SPEED, 32'h8000_0000);
        write_reg(REG_DIRX, -32'sd16384);
        write_reg(REG_DIRY, -32'sd16384);
        write_reg(REG_DIRZ, -32'sd16384);
        write_reg(REG_START, 32'hffff_ffff);
      end
      default: begin
        write_reg(REG_STIFF, ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 20));
        write_reg(REG_REST, ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 22));
        write_reg(REG_SPEED, ($urandom_range(0, 3) == 0) ? $urandom()
                                                         : $urandom_range(0, 1 << 17) - (1 << 16));
        write_reg(REG_DIRX, rand_dir());
        write_reg(REG_DIRY, rand_dir());
        write_reg(REG_DIRZ, rand_dir());
        write_reg(REG_START, $urandom());
      end
    endcase
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 1 << 21) - (1 << 20);
    endcase
  endfunction

  function automatic logic [31:0] rand_now();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'd0;
      default: return start_reg + $urandom_range(0, 64);
    endcase
  endfunction

  // result side: random stalls, compare against the oldest expectation
  initial begin
    force_t got, want;
    int stall;
    out_tready = 0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
      got.fx = out_tdata[31:0];
      got.fy = out_tdata[63:32];
      got.fz = out_tdata[95:64];
      got.extent = out_tdata[127:96];
      got.zero_len = out_tdata[128];
      got.sat = out_tdata[129];
      forces_seen++;
      if (expected_forces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = expected_forces.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d: expected %p, got %p", forces_seen, want, got);
        end
      end
    end
  end

  row_t rows [$];
  int sent;

  initial begin
    row_t rw;
    force_t none;
    int len, ph;
    logic op;
    none = '{default: 0};
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = 0;
    in_tlast = 0;
    in_tdata = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    k_reg = 32'd65536;
    rest_reg = 0;
    speed_reg = 0;
    dir_reg = '{16'sd16384, 16'sd0, 16'sd0};
    start_reg = 0;
    bead_sum = '{0, 0, 0};
    bead_cnt = 0;
    anchor = '{0, 0, 0};
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // force pass before any capture: zero anchor, bead at origin
    rows.push_back('{1, 0, 0, 0, 1, 0, 1, '{0, 0, 0, 0, 1, 0}});
    // bead at x = 1.0, unit stiffness: pulled back by one unit
    rows.push_back('{1, 32'h1_0000, 0, 0, 1, 0, 1,
                     '{32'hffff_0000, 0, 0, 32'h1_0000, 0, 0}});
    // op on non-last beads is ignored
    rows.push_back('{1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, none});
    rows.push_back('{0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 5, 0, none});
    rows.push_back('{1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 32'hffff_ffff, 0, none});
    rows.push_back('{0, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0, none});
    rows.push_back('{1, 32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678, 1, 32'h8000_0000, 0, none});
    rows.push_back('{0, 32'hffff_ffff, 1, 32'haaaa_aaaa, 1, 0, 0, none});
    rows.push_back('{1, 32'h5555_5555, 32'hffff_ffff, 32'hcccc_cccc, 1, 32'h3333_3333, 0, none});
    rows.push_back('{1, 32'h0000_8000, 32'hffff_8000, 32'h0001_0000, 1, 32'hffff_ffff, 0, none});
    foreach (rows[i]) begin
      rw = rows[i];
      send_bead(rw.op, rw.px, rw.py, rw.pz, rw.lb, rw.now, rw.typed, rw.want);
    end

    // extreme settings with short passes, then random ones
    ph = 1;
    sent = 0;
    while (sent < RandomBeads) begin
      if (sent >= (ph - 1) * 200) begin
        set_regs(ph);
        ph++;
        no_idle = ($urandom_range(0, 3) == 0);
      end
      op = ($urandom_range(0, 9) < 3) ? 0 : 1;
      if (ph == 5 && bead_cnt == 0 && sent < 900) len = MaxBeads + 6;
      else len = $urandom_range(1, 6);
      for (int b = 1; b <= len; b++) begin
        send_bead(($urandom_range(0, 3) == 0) ? ~op : op, rand_pos(), rand_pos(), rand_pos(),
                  b == len, rand_now(), 0, none);
        sent++;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_bead(1, rand_pos(), rand_pos(), rand_pos(), 1, rand_now(), 0, none);
        sent++;
      end
    end

    drain();
    $display("%0d beads in %0d passes (%0d captures), %0d force results, %0d register phases",
             sent + rows.size(), passes_done, captures_done, forces_seen, ph - 1);
    $display("%0d mismatches, %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/cvsp_pkg.sv
hw/rtl/cvsp_regs.sv
hw/rtl/cvsp_divu.sv
hw/rtl/constant_velocity_spring_pull_force_unit.sv
bench/tb_constant_velocity_spring_pull_force_unit.sv
